[src/gmj_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gmj_pkg;

  localparam int MAX_COLS  = 64;
  localparam int MAX_ROWS  = 64;
  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;

  localparam int IDX_W   = 6;
  localparam int DIM_W   = 7;
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int ADDR_W  = COL_W + ROW_W;
  localparam int DEPTH   = MAX_COLS * MAX_ROWS;

  // doubled derivative, product of two of them, divider numerator
  localparam int D_W     = COORD_W + 4;
  localparam int P_W     = 2 * D_W;
  localparam int NUM_W   = D_W + 2 * FRAC_BITS + 2;
  localparam int PART_W  = D_W / 2;
  localparam int HI_W    = D_W - PART_W;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 168;
  localparam int N_RES      = 5;

  typedef enum logic [0:0] {
    REG_GRID_COLS = 1'b0,
    REG_GRID_ROWS = 1'b1
  } reg_index_t;

  typedef enum logic [0:0] {
    FN_LOAD    = 1'b0,
    FN_COMPUTE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DET = 2'd1,
    ST_RANGE    = 2'd2,
    ST_SAT      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_CHECK,
    S_DIV_START,
    S_DIV_WAIT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    EK_LOW,
    EK_HIGH,
    EK_MID
  } edge_kind_t;

  typedef struct packed {
    logic signed [2:0] off;
    logic signed [3:0] coef;
  } tap_t;

  typedef struct packed {
    logic               done;
    logic               sat;
    logic [COORD_W-1:0] quot;
  } div_res_t;

  // three-point stencil taps; derivative is held doubled
  function automatic tap_t tap_sel(edge_kind_t k, logic [1:0] t);
    tap_t r;
    r.off  = 3'sd0;
    r.coef = 4'sd0;
    case (k)
      EK_LOW: begin
        case (t)
          2'd0: begin r.off = 3'sd0; r.coef = -4'sd3; end
          2'd1: begin r.off = 3'sd1; r.coef = 4'sd4; end
          default: begin r.off = 3'sd2; r.coef = -4'sd1; end
        endcase
      end
      EK_HIGH: begin
        case (t)
          2'd0: begin r.off = 3'sd0; r.coef = 4'sd3; end
          2'd1: begin r.off = -3'sd1; r.coef = -4'sd4; end
          default: begin r.off = -3'sd2; r.coef = 4'sd1; end
        endcase
      end
      default: begin
        case (t)
          2'd0: begin r.off = 3'sd0; r.coef = 4'sd0; end
          2'd1: begin r.off = 3'sd1; r.coef = 4'sd1; end
          default: begin r.off = -3'sd1; r.coef = -4'sd1; end
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[src/gmj_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module gmj_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic signed [gmj_pkg::NUM_W-1:0] num,
  input  wire logic signed [gmj_pkg::P_W-1:0]   den,
  output gmj_pkg::div_res_t                   res
);
  import gmj_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [NUM_W-1:0] LIMIT = NUM_W'(1) << (COORD_W - 1);

  logic               busy;
  logic               fin;
  logic [CNT_W-1:0]   cnt;
  logic [NUM_W-1:0]   nmag;
  logic [P_W-1:0]     dmag;
  logic [P_W-1:0]     rem;
  logic [NUM_W-1:0]   q;
  logic               neg;

  logic [P_W:0]       rem_sh;
  logic [P_W:0]       rem_diff;
  logic               ge;
  logic [NUM_W-1:0]   q_neg;

  assign rem_sh   = {rem, nmag[NUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, dmag};
  assign ge       = rem_sh >= {1'b0, dmag};
  assign q_neg    = ~q + NUM_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      cnt  <= '0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  // restoring divide on magnitudes, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      nmag <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      dmag <= den[P_W-1] ? P_W'(-den) : P_W'(den);
      neg  <= num[NUM_W-1] ^ den[P_W-1];
      rem  <= '0;
      q    <= '0;
    end else if (busy) begin
      rem  <= ge ? rem_diff[P_W-1:0] : rem_sh[P_W-1:0];
      q    <= {q[NUM_W-2:0], ge};
      nmag <= {nmag[NUM_W-2:0], 1'b0};
    end
  end

  always_comb begin
    res.done = fin;
    res.sat  = 1'b0;
    if (neg) begin
      if (q > LIMIT) begin
        res.sat  = 1'b1;
        res.quot = LIMIT[COORD_W-1:0];
      end else begin
        res.quot = q_neg[COORD_W-1:0];
      end
    end else begin
      if (q >= LIMIT) begin
        res.sat  = 1'b1;
        res.quot = {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
        res.quot = q[COORD_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

[src/grid_metric_jacobian.sv]
`timescale 1ns / 1ps
`default_nettype none
// Load word: written straight into the coordinate RAMs.
// Compute word, from acceptance to the result word: the stencil RAM reads,
// 4 partial products, one check, five divides in one shared divider
// (a zero determinant stops at the check, an out-of-range index skips all).
// One word at a time; the result register lets the next word in while it waits.
// Reset (rst, synchronous): grid 64 x 64, controller idle, output empty, RAMs kept.

module grid_metric_jacobian (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [0:0]                        cfg_index,
  input  wire logic [gmj_pkg::DIM_W-1:0]         cfg_data,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // col_index[5:0], row_index[11:6], x_coord[43:12], y_coord[75:44], zero pad
  input  wire logic [gmj_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // func[0]
  input  wire logic [0:0]                        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // ksi_dx[31:0], ksi_dy[63:32], eta_dx[95:64], eta_dy[127:96],
  // inv_jacobian[159:128], status[161:160], zero pad
  output logic [gmj_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);
  import gmj_pkg::*;

  // ---------------- configuration ----------------
  logic [DIM_W-1:0] grid_cols;
  logic [DIM_W-1:0] grid_rows;
  logic [DIM_W-1:0] nc;
  logic [DIM_W-1:0] nr;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= DIM_W'(64);
      grid_rows <= DIM_W'(64);
    end else if (cfg_wr_en) begin
      case (reg_index_t'(cfg_index))
        REG_GRID_COLS: grid_cols <= cfg_data;
        REG_GRID_ROWS: grid_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  // out-of-range sizes act as the nearest legal size
  always_comb begin
    nc = grid_cols;
    if (grid_cols < DIM_W'(3)) nc = DIM_W'(3);
    else if (grid_cols > DIM_W'(MAX_COLS)) nc = DIM_W'(MAX_COLS);
    nr = grid_rows;
    if (grid_rows < DIM_W'(3)) nr = DIM_W'(3);
    else if (grid_rows > DIM_W'(MAX_ROWS)) nr = DIM_W'(MAX_ROWS);
  end

  // ---------------- input word ----------------
  logic                       in_acc;
  func_t                      in_func;
  logic [IDX_W-1:0]           in_col;
  logic [IDX_W-1:0]           in_row;
  logic [COORD_W-1:0]         in_x;
  logic [COORD_W-1:0]         in_y;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_func = func_t'(s_axis_tuser[0]);
  assign in_col  = s_axis_tdata[5:0];
  assign in_row  = s_axis_tdata[11:6];
  assign in_x    = s_axis_tdata[43:12];
  assign in_y    = s_axis_tdata[75:44];

  // ---------------- coordinate RAMs ----------------
  logic [COORD_W-1:0] x_mem [DEPTH];
  logic [COORD_W-1:0] y_mem [DEPTH];
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic [COORD_W-1:0] x_rd;
  logic [COORD_W-1:0] y_rd;

  assign wr_en   = in_acc && (in_func == FN_LOAD);
  assign wr_addr = {COL_W'(in_col), ROW_W'(in_row)};

  // loads land only while idle, so a read never overlaps a write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem[wr_addr] <= in_x;
      y_mem[wr_addr] <= in_y;
    end
    x_rd <= x_mem[rd_addr];
    y_rd <= y_mem[rd_addr];
  end

  // ---------------- controller ----------------
  state_t             state;
  state_t             state_next;
  logic [IDX_W-1:0]   ci;
  logic [IDX_W-1:0]   rj;
  edge_kind_t         ki;
  edge_kind_t         kj;
  logic [2:0]         rcnt;
  logic [1:0]         mcnt;
  logic [2:0]         div_idx;
  logic               sat_any;
  logic               out_free;
  logic               range_bad;

  logic               rd_dir;
  logic [1:0]         rd_tap;
  tap_t               tp;
  logic [IDX_W-1:0]   ci_off;
  logic [IDX_W-1:0]   rj_off;
  logic signed [3:0]  coef_q;
  logic               dir_q;

  logic signed [D_W-1:0] dxk;
  logic signed [D_W-1:0] dyk;
  logic signed [D_W-1:0] dxi;
  logic signed [D_W-1:0] dyi;
  logic signed [P_W-1:0] det4;

  logic [COORD_W-1:0] res [N_RES];
  status_t            res_status;

  div_res_t                  div_res;
  logic                      div_start;
  logic signed [NUM_W-1:0]   div_num;

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign range_bad = ({1'b0, in_col} >= nc) || ({1'b0, in_row} >= nr);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc && in_func == FN_COMPUTE) state_next = range_bad ? S_DONE : S_READ;
      end
      S_READ:      if (rcnt == 3'd6) state_next = S_MUL;
      S_MUL:       if (mcnt == 2'd3) state_next = S_CHECK;
      S_CHECK:     state_next = (det4 == '0) ? S_DONE : S_DIV_START;
      S_DIV_START: state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_res.done) state_next = (div_idx == 3'(N_RES - 1)) ? S_DONE : S_DIV_START;
      end
      S_DONE:      if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == S_IDLE);
    div_start     = (state == S_DIV_START);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // ---------------- stencil reads ----------------
  // three taps along i (stride MAX_ROWS), then three along j
  assign rd_dir = (rcnt >= 3'd3);
  assign rd_tap = rd_dir ? 2'(rcnt - 3'd3) : rcnt[1:0];
  assign tp     = tap_sel(rd_dir ? kj : ki, rd_tap);
  assign ci_off = rd_dir ? ci : ci + {{(IDX_W-3){tp.off[2]}}, tp.off};
  assign rj_off = rd_dir ? rj + {{(IDX_W-3){tp.off[2]}}, tp.off} : rj;
  assign rd_addr = {COL_W'(ci_off), ROW_W'(rj_off)};

  function automatic logic signed [D_W-1:0] scale(logic [COORD_W-1:0] v,
                                                  logic signed [3:0] k);
    logic signed [D_W-1:0] s;
    s = D_W'(signed'(v));
    case (k)
      4'sd1:   return s;
      -4'sd1:  return -s;
      4'sd3:   return (s <<< 1) + s;
      -4'sd3:  return -((s <<< 1) + s);
      4'sd4:   return s <<< 2;
      -4'sd4:  return -(s <<< 2);
      default: return '0;
    endcase
  endfunction

  // ---------------- determinant partial products ----------------
  logic signed [D_W-1:0]        ma;
  logic signed [D_W-1:0]        mb;
  logic signed [PART_W:0]       mpart;
  logic signed [D_W+PART_W:0]   mprod;
  logic signed [P_W-1:0]        mterm;

  assign ma    = mcnt[1] ? dxi : dxk;
  assign mb    = mcnt[1] ? dyk : dyi;
  // upper half carries the sign, lower half is a plain magnitude
  assign mpart = mcnt[0] ? {{(PART_W+1-HI_W){mb[D_W-1]}}, mb[D_W-1:PART_W]}
                         : {1'b0, mb[PART_W-1:0]};
  assign mprod = ma * mpart;
  assign mterm = mcnt[0] ? (P_W'(mprod) <<< PART_W) : P_W'(mprod);

  // ---------------- divider feed ----------------
  always_comb begin
    case (div_idx)
      3'd0:    div_num = NUM_W'(dyi) <<< (2 * FRAC_BITS + 1);
      3'd1:    div_num = -(NUM_W'(dxi) <<< (2 * FRAC_BITS + 1));
      3'd2:    div_num = -(NUM_W'(dyk) <<< (2 * FRAC_BITS + 1));
      3'd3:    div_num = NUM_W'(dxk) <<< (2 * FRAC_BITS + 1);
      default: div_num = NUM_W'(4) <<< (3 * FRAC_BITS);
    endcase
  end

  gmj_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (det4),
    .res   (div_res)
  );

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rcnt    <= '0;
      mcnt    <= '0;
      div_idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          rcnt <= '0;
          mcnt <= '0;
        end
        S_READ:      rcnt <= rcnt + 3'd1;
        S_MUL:       mcnt <= mcnt + 2'd1;
        S_CHECK:     div_idx <= '0;
        S_DIV_WAIT:  if (div_res.done) div_idx <= div_idx + 3'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        ci  <= in_col;
        rj  <= in_row;
        ki  <= (in_col == '0) ? EK_LOW :
               ({1'b0, in_col} == nc - DIM_W'(1)) ? EK_HIGH : EK_MID;
        kj  <= (in_row == '0) ? EK_LOW :
               ({1'b0, in_row} == nr - DIM_W'(1)) ? EK_HIGH : EK_MID;
        dxk <= '0;
        dyk <= '0;
        dxi <= '0;
        dyi <= '0;
        det4 <= '0;
        sat_any <= 1'b0;
        for (int r = 0; r < N_RES; r++) res[r] <= '0;
        res_status <= ST_RANGE;
      end
      S_READ: begin
        coef_q <= tp.coef;
        dir_q  <= rd_dir;
        if (rcnt != 3'd0) begin
          if (dir_q) begin
            dxi <= dxi + scale(x_rd, coef_q);
            dyi <= dyi + scale(y_rd, coef_q);
          end else begin
            dxk <= dxk + scale(x_rd, coef_q);
            dyk <= dyk + scale(y_rd, coef_q);
          end
        end
      end
      S_MUL:   det4 <= mcnt[1] ? det4 - mterm : det4 + mterm;
      S_CHECK: res_status <= ST_ZERO_DET;
      S_DIV_WAIT: begin
        if (div_res.done) begin
          res[div_idx] <= div_res.quot;
          sat_any      <= sat_any | div_res.sat;
          if (div_idx == 3'(N_RES - 1))
            res_status <= (sat_any | div_res.sat) ? ST_SAT : ST_OK;
        end
      end
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_axis_tdata <= {6'd0, res_status, res[4], res[3], res[2], res[1], res[0]};
    end
  end

  // ---------------- assertions ----------------
  a_div_only_when_waiting: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> state == S_DIV_WAIT)
    else $error("divider finished outside a divide step");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_DONE))
    else $error("result word appeared without a finished compute");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[161:160] == ST_RANGE |-> m_axis_tdata[159:0] == '0)
    else $error("out-of-range result carries nonzero values");

endmodule

`default_nettype wire
